// ===== rtl/flvtw_pkg.sv =====
// Shared types and constants for the tag walker.
package flvtw_pkg;

    localparam logic [23:0] FILE_HDR_LEN   = 24'd13;
    localparam logic [23:0] TAG_HDR_LEN    = 24'd11;
    localparam logic [23:0] SIZE_WORD_LEN  = 24'd4;
    localparam logic [23:0] SIZE_LAST_IDX  = 24'd3;
    localparam logic [4:0]  DEFAULT_TARGET = 5'd18;

    typedef enum logic [1:0] {
        PH_FILE_HDR = 2'd0,
        PH_TAG_HDR  = 2'd1,
        PH_DATA     = 2'd2,
        PH_PREV     = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        ST_SEARCH   = 2'd0,
        ST_FOUND    = 2'd1,
        ST_MISMATCH = 2'd2,
        ST_TRUNC    = 2'd3
    } status_t;

    typedef struct packed {
        phase_t      phase;
        logic [23:0] phase_count;
        logic [4:0]  tag_kind;
        logic [23:0] tag_data_size;
        logic [31:0] size_word;
        logic [31:0] byte_offset;
        status_t     status;
    } walk_state_t;

    localparam walk_state_t WALK_RESTART = '{
        phase:         PH_FILE_HDR,
        phase_count:   24'd0,
        tag_kind:      5'd0,
        tag_data_size: 24'd0,
        size_word:     32'd0,
        byte_offset:   32'd0,
        status:        ST_SEARCH
    };

endpackage

// ===== rtl/flv_tag_walker_core.sv =====
// An accepted item passes through the input register, then the result register,
// from which it leaves when m_ready is high.
// Throughput: one item per cycle unless m_ready stalls; one walk state step per byte.
// Each item gives exactly one result with the current status and prefix length.
// Reset (aresetn low, synchronous) empties both stages, restarts the walk and
// sets the target type to 18.
module flv_tag_walker_core (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_target_type,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_first_byte,
    input  logic        s_last_byte,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [31:0] m_prefix_length
);

    logic                   in_valid_reg;
    logic [7:0]             in_byte_reg;
    logic                   in_first_reg;
    logic                   in_last_reg;
    logic                   advance;

    logic [4:0]             target_reg;
    flvtw_pkg::walk_state_t walk_reg;
    flvtw_pkg::walk_state_t walk_next;

    logic                   out_valid_reg;
    logic [1:0]             out_status_reg;
    logic [31:0]            out_prefix_reg;

    assign cfg_ready = 1'b1;

    // The input stage moves on when the result register is free or drains now.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg <= flvtw_pkg::DEFAULT_TARGET;
        end else if (cfg_valid && cfg_ready) begin
            target_reg <= cfg_target_type;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg  <= s_data_byte;
            in_first_reg <= s_first_byte;
            in_last_reg  <= s_last_byte;
        end
    end

    flvtw_walk_step u_step (
        .cur_state   (walk_reg),
        .data_byte   (in_byte_reg),
        .first_byte  (in_first_reg),
        .last_byte   (in_last_reg),
        .target_type (target_reg),
        .next_state  (walk_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            walk_reg <= flvtw_pkg::WALK_RESTART;
        end else if (advance) begin
            walk_reg <= walk_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_status_reg <= walk_next.status;
            if (walk_next.status == flvtw_pkg::ST_FOUND) begin
                out_prefix_reg <= walk_next.byte_offset;
            end else begin
                out_prefix_reg <= 32'd0;
            end
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_status        = out_status_reg;
    assign m_prefix_length = out_prefix_reg;

`ifndef ASSERT_OFF
    a_prefix_zero_unless_found: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != flvtw_pkg::ST_FOUND) |-> (m_prefix_length == 32'd0))
        else $error("prefix length is nonzero without a found status");

    a_final_status_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && !in_first_reg && walk_reg.status != flvtw_pkg::ST_SEARCH)
        |=> (walk_reg == $past(walk_reg)))
        else $error("walk state changed after a final status without a restart");

    a_header_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (walk_reg.phase == flvtw_pkg::PH_FILE_HDR) |->
        (walk_reg.phase_count < flvtw_pkg::FILE_HDR_LEN))
        else $error("file header count ran past the header length");

    a_stage_holds_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_byte_reg)))
        else $error("input stage lost an item while stalled");
`endif

endmodule

// ===== rtl/flvtw_walk_step.sv =====
// Next-state logic of the tag walk for one byte.
module flvtw_walk_step (
    input  flvtw_pkg::walk_state_t cur_state,
    input  logic [7:0]             data_byte,
    input  logic                   first_byte,
    input  logic                   last_byte,
    input  logic [4:0]             target_type,
    output flvtw_pkg::walk_state_t next_state
);

    flvtw_pkg::walk_state_t base;
    logic [23:0]            cnt_inc;
    logic [31:0]            sw_new;
    logic [31:0]            expected_size;

    // A restart mark clears the walk before the byte counts as offset zero.
    always_comb begin
        if (first_byte) begin
            base = flvtw_pkg::WALK_RESTART;
        end else begin
            base = cur_state;
        end
    end

    assign cnt_inc       = base.phase_count + 24'd1;
    assign sw_new        = {base.size_word[23:0], data_byte};
    assign expected_size = {8'd0, base.tag_data_size} + {8'd0, flvtw_pkg::TAG_HDR_LEN};

    always_comb begin
        next_state = base;
        if (base.status == flvtw_pkg::ST_SEARCH) begin
            next_state.byte_offset = base.byte_offset + 32'd1;
            next_state.phase_count = cnt_inc;
            unique case (base.phase)
                flvtw_pkg::PH_FILE_HDR: begin
                    if (cnt_inc >= flvtw_pkg::FILE_HDR_LEN) begin
                        next_state.phase       = flvtw_pkg::PH_TAG_HDR;
                        next_state.phase_count = 24'd0;
                    end
                end
                flvtw_pkg::PH_TAG_HDR: begin
                    if (base.phase_count == 24'd0) begin
                        next_state.tag_kind      = data_byte[4:0];
                        next_state.tag_data_size = 24'd0;
                    end else if (base.phase_count <= flvtw_pkg::SIZE_LAST_IDX) begin
                        next_state.tag_data_size = {base.tag_data_size[15:0], data_byte};
                    end
                    if (cnt_inc >= flvtw_pkg::TAG_HDR_LEN) begin
                        next_state.phase_count = 24'd0;
                        next_state.size_word   = 32'd0;
                        // The size is complete long before the header ends.
                        if (base.tag_data_size == 24'd0) begin
                            next_state.phase = flvtw_pkg::PH_PREV;
                        end else begin
                            next_state.phase = flvtw_pkg::PH_DATA;
                        end
                    end
                end
                flvtw_pkg::PH_DATA: begin
                    if (cnt_inc >= base.tag_data_size) begin
                        next_state.phase_count = 24'd0;
                        next_state.size_word   = 32'd0;
                        next_state.phase       = flvtw_pkg::PH_PREV;
                    end
                end
                flvtw_pkg::PH_PREV: begin
                    next_state.size_word = sw_new;
                    if (cnt_inc >= flvtw_pkg::SIZE_WORD_LEN) begin
                        next_state.phase_count = 24'd0;
                        if (sw_new != expected_size) begin
                            next_state.status = flvtw_pkg::ST_MISMATCH;
                        end else if (base.tag_kind == target_type) begin
                            next_state.status = flvtw_pkg::ST_FOUND;
                        end else begin
                            next_state.phase = flvtw_pkg::PH_TAG_HDR;
                        end
                    end
                end
                default: begin
                    next_state = base;
                end
            endcase
            if (last_byte && next_state.status == flvtw_pkg::ST_SEARCH) begin
                next_state.status = flvtw_pkg::ST_TRUNC;
            end
        end
    end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the tag walker core: streams files and checks every item.
module tb;

    // Follows the walk byte by byte and keeps the status items still to come.
    class tag_walk_tracker;
        typedef struct {
            flvtw_pkg::status_t st;
            logic [31:0]        prefix_len;
        } walk_status_t;

        flvtw_pkg::phase_t  phase;
        logic [23:0]        phase_count;
        logic [4:0]         tag_kind;
        logic [23:0]        tag_data_size;
        logic [31:0]        size_word;
        logic [31:0]        byte_offset;
        flvtw_pkg::status_t status;
        logic [4:0]         target;
        walk_status_t       expected_q[$];
        int                 errors;

        function new();
            target = flvtw_pkg::DEFAULT_TARGET;
            errors = 0;
            restart();
        endfunction

        function void restart();
            phase         = flvtw_pkg::PH_FILE_HDR;
            phase_count   = '0;
            tag_kind      = '0;
            tag_data_size = '0;
            size_word     = '0;
            byte_offset   = '0;
            status        = flvtw_pkg::ST_SEARCH;
        endfunction

        function void advance(logic [7:0] b);
            byte_offset = byte_offset + 32'd1;
            case (phase)
                flvtw_pkg::PH_FILE_HDR: begin
                    phase_count = phase_count + 24'd1;
                    if (phase_count >= flvtw_pkg::FILE_HDR_LEN) begin
                        phase       = flvtw_pkg::PH_TAG_HDR;
                        phase_count = '0;
                    end
                end
                flvtw_pkg::PH_TAG_HDR: begin
                    if (phase_count == 24'd0) begin
                        tag_kind      = b[4:0];
                        tag_data_size = '0;
                    end else if (phase_count <= flvtw_pkg::SIZE_LAST_IDX) begin
                        tag_data_size = {tag_data_size[15:0], b};
                    end
                    phase_count = phase_count + 24'd1;
                    if (phase_count >= flvtw_pkg::TAG_HDR_LEN) begin
                        phase_count = '0;
                        size_word   = '0;
                        phase       = (tag_data_size == 24'd0) ? flvtw_pkg::PH_PREV
                                                               : flvtw_pkg::PH_DATA;
                    end
                end
                flvtw_pkg::PH_DATA: begin
                    phase_count = phase_count + 24'd1;
                    if (phase_count >= tag_data_size) begin
                        phase_count = '0;
                        size_word   = '0;
                        phase       = flvtw_pkg::PH_PREV;
                    end
                end
                default: begin
                    size_word   = {size_word[23:0], b};
                    phase_count = phase_count + 24'd1;
                    if (phase_count >= flvtw_pkg::SIZE_WORD_LEN) begin
                        phase_count = '0;
                        if (size_word != {8'd0, tag_data_size}
                                         + {8'd0, flvtw_pkg::TAG_HDR_LEN})
                            status = flvtw_pkg::ST_MISMATCH;
                        else if (tag_kind == target)
                            status = flvtw_pkg::ST_FOUND;
                        else
                            phase = flvtw_pkg::PH_TAG_HDR;
                    end
                end
            endcase
        endfunction

        function void note_byte(logic [7:0] b, bit first, bit last);
            walk_status_t item;
            if (first)
                restart();
            if (status == flvtw_pkg::ST_SEARCH) begin
                advance(b);
                if (last && status == flvtw_pkg::ST_SEARCH)
                    status = flvtw_pkg::ST_TRUNC;
            end
            item.st         = status;
            item.prefix_len = (status == flvtw_pkg::ST_FOUND) ? byte_offset : 32'd0;
            expected_q.push_back(item);
        endfunction

        task report(string msg);
            $display("[%0t] MISMATCH: %s", $realtime, msg);
            errors++;
        endtask

        task check_status(logic [1:0] st, logic [31:0] len);
            walk_status_t want;
            if (expected_q.size() == 0) begin
                report($sformatf("status %0d arrived with nothing expected", st));
                return;
            end
            want = expected_q.pop_front();
            if (st !== want.st)
                report($sformatf("status %0d, expected %0d", st, want.st));
            if (len !== want.prefix_len)
                report($sformatf("prefix_length %0d, expected %0d", len, want.prefix_len));
        endtask
    endclass

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [4:0]  cfg_target_type;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_data_byte;
    logic        s_first_byte;
    logic        s_last_byte;
    logic        m_valid;
    logic        m_ready;
    logic [1:0]  m_status;
    logic [31:0] m_prefix_length;

    tag_walk_tracker sb = new();
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int live_items    = 0;

    flv_tag_walker_core dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_target_type (cfg_target_type),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_byte     (s_data_byte),
        .s_first_byte    (s_first_byte),
        .s_last_byte     (s_last_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_prefix_length (m_prefix_length)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_status(m_status, m_prefix_length);
    end

    initial begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic send_byte(input logic [7:0] b, input bit first, input bit last);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        live_items++;
        s_valid      <= 1'b1;
        s_data_byte  <= b;
        s_first_byte <= first;
        s_last_byte  <= last;
        do @(posedge aclk); while (!s_ready);
        sb.note_byte(b, first, last);
        @(negedge aclk);
    endtask

    task automatic send_stream(ref logic [7:0] bytes[$], input bit mark_first,
                               input bit mark_last);
        for (int i = 0; i < bytes.size(); i++)
            send_byte(bytes[i], mark_first && i == 0, mark_last && i == bytes.size() - 1);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_target(input logic [4:0] t);
        wait_idle();
        cfg_valid       <= 1'b1;
        cfg_target_type <= t;
        do @(posedge aclk); while (!cfg_ready);
        sb.target = t;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic void add_file_header(ref logic [7:0] q[$]);
        q.push_back(8'h46);
        q.push_back(8'h4C);
        q.push_back(8'h56);
        repeat (10) q.push_back(8'($urandom));
    endfunction

    // Appends one tag; a tag larger than max_data is cut after max_data data bytes and
    // the function returns 0.
    function automatic bit add_tag(ref logic [7:0] q[$], input logic [7:0] kind_byte,
                                   input logic [23:0] size, input bit bad_prev,
                                   input int max_data);
        logic [31:0] word;
        int          n;
        q.push_back(kind_byte);
        q.push_back(size[23:16]);
        q.push_back(size[15:8]);
        q.push_back(size[7:0]);
        repeat (7) q.push_back(8'($urandom));
        n = (size > max_data) ? max_data : int'(size);
        repeat (n) q.push_back(8'($urandom));
        if (size > max_data)
            return 1'b0;
        word = {8'd0, size} + 32'd11;
        if (bad_prev)
            word = word ^ (32'd1 << $urandom_range(0, 31));
        q.push_back(word[31:24]);
        q.push_back(word[23:16]);
        q.push_back(word[15:8]);
        q.push_back(word[7:0]);
        return 1'b1;
    endfunction

    task automatic directed_files();
        logic [7:0] f[$];
        bit         ok;

        // Reset target, no restart mark, found on the very last byte, then ignored bytes.
        add_file_header(f);
        ok = add_tag(f, 8'd18, 24'd0, 1'b0, 64);
        send_stream(f, 1'b0, 1'b1);
        send_byte(8'hFF, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b1);

        // The upper bits of the type byte must be masked off.
        write_target(5'd0);
        f.delete();
        add_file_header(f);
        ok = add_tag(f, 8'h1F, 24'd3, 1'b0, 64);
        ok = add_tag(f, 8'hE0, 24'd1, 1'b0, 64);
        send_stream(f, 1'b1, 1'b1);

        write_target(5'd31);
        f.delete();
        add_file_header(f);
        ok = add_tag(f, 8'h05, 24'd2, 1'b0, 64);
        ok = add_tag(f, 8'hFF, 24'd0, 1'b1, 64);
        send_stream(f, 1'b1, 1'b1);

        // A restart mark in the middle of a walk.
        f.delete();
        add_file_header(f);
        repeat (7) f.push_back(8'h00);
        send_stream(f, 1'b1, 1'b0);
        f.delete();
        add_file_header(f);
        ok = add_tag(f, 8'h3F, 24'd0, 1'b0, 64);
        send_stream(f, 1'b1, 1'b0);

        // Largest data size, cut short by the end of the file.
        f.delete();
        add_file_header(f);
        ok = add_tag(f, 8'h02, 24'hFFFFFF, 1'b0, 5);
        send_stream(f, 1'b1, 1'b1);

        // A one-byte file, and a file that ends inside a tag header.
        send_byte(8'h00, 1'b1, 1'b1);
        f.delete();
        add_file_header(f);
        f.push_back(8'h1F);
        f.push_back(8'hFF);
        send_stream(f, 1'b1, 1'b1);
    endtask

    task automatic random_file();
        logic [7:0]  bytes[$];
        logic [7:0]  kind_byte;
        logic [23:0] size;
        int          roll;
        int          ntags;
        int          cut;
        bit          whole;
        bit          mark_first;
        roll = $urandom_range(0, 99);
        if (roll < 6) begin
            repeat ($urandom_range(1, 12))
                send_byte(8'($urandom), $urandom_range(0, 7) == 0, $urandom_range(0, 7) == 0);
            return;
        end
        add_file_header(bytes);
        ntags = $urandom_range(1, 4);
        whole = 1'b1;
        for (int t = 0; t < ntags && whole; t++) begin
            kind_byte = 8'($urandom);
            if ($urandom_range(0, 1))
                kind_byte[4:0] = sb.target;
            roll = $urandom_range(0, 99);
            if (roll < 70)
                size = 24'($urandom_range(0, 8));
            else if (roll < 96)
                size = 24'($urandom_range(9, 48));
            else
                size = 24'($urandom);
            whole = add_tag(bytes, kind_byte, size, $urandom_range(0, 11) == 0, 64);
        end
        mark_first = ($urandom_range(0, 19) != 0);
        roll = $urandom_range(0, 99);
        if (whole && roll < 18) begin
            cut   = $urandom_range(1, bytes.size());
            bytes = bytes[0:cut-1];
            send_stream(bytes, mark_first, roll < 12);
        end else begin
            send_stream(bytes, mark_first, 1'b1);
        end
    endtask

    task automatic random_files(input int goal);
        int roll;
        while (live_items < goal) begin
            if ($urandom_range(0, 9) == 0) begin
                roll = $urandom_range(0, 3);
                write_target(roll == 0 ? 5'd0 : roll == 1 ? 5'd31 : 5'($urandom));
            end else if ($urandom_range(0, 14) == 0) begin
                wait_idle();
            end
            random_file();
        end
    endtask

    initial begin
        aresetn         = 1'b0;
        cfg_valid       = 1'b0;
        cfg_target_type = '0;
        s_valid         = 1'b0;
        s_data_byte     = '0;
        s_first_byte    = 1'b0;
        s_last_byte     = 1'b0;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_idle_pct = 35;
        recv_idle_pct = 70;
        directed_files();
        random_files(240);

        wait_idle();
        send_idle_pct = 70;
        recv_idle_pct = 35;
        random_files(480);

        wait_idle();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_files(700);

        wait_idle();
        repeat (10) @(posedge aclk);
        if (sb.expected_q.size() != 0)
            sb.report($sformatf("%0d status items never arrived", sb.expected_q.size()));
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
